// ===== src/plt_pkg.sv =====
// ----------------------------------------------------------------------------
// Power-law transfer package
// Widths, constants, register codes and the table builders that the power-law
// transfer block and its log and exp units share.
// ----------------------------------------------------------------------------
package plt_pkg;

  localparam int unsigned FRAC_BITS           = 16;
  localparam int unsigned DEF_TABLE_ADDR_BITS = 10;

  localparam int unsigned VAL_W     = 24;
  localparam int unsigned RES_W     = 25;
  localparam int unsigned GAM_W     = 16;
  localparam int unsigned ALPHA_W   = 24;
  localparam int unsigned BETA_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 24;

  localparam int unsigned LOGIN_W = VAL_W + 1;
  localparam int unsigned LOG_W   = 36;
  localparam int unsigned Y_W     = 41;
  localparam int unsigned P_W     = 42;

  localparam int unsigned LOG_LAT = 9;
  localparam int unsigned SCL_LAT = 3;
  localparam int unsigned EXP_LAT = 6;

  localparam logic [30:0] LN2_Q30    = 31'd744261118;
  localparam logic [30:0] INVLN2_Q30 = 31'd1549082005;
  localparam logic [16:0] DIV3_MUL   = 17'd43691;

  localparam logic [P_W-1:0]   CAP_Q    = P_W'(1) << 41;
  localparam logic [RES_W-1:0] MAX_RES  = RES_W'(24'hFFFFFF);

  localparam logic [GAM_W-1:0]   GAMMA_RST     = 16'd9830;
  localparam logic [GAM_W-1:0]   INV_GAMMA_RST = 16'd27307;
  localparam logic [ALPHA_W-1:0] ALPHA_RST     = 24'd65536;
  localparam logic [BETA_W-1:0]  BETA_RST      = 16'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAMMA     = 2'd0,
    CFG_INV_GAMMA = 2'd1,
    CFG_ALPHA     = 2'd2,
    CFG_BETA      = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic vld;
    logic cmd;
    logic alpha0;
    logic exp0;
    logic base0;
  } side_t;

  function automatic logic [63:0] udiv_f(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [29:0] log2_bits_f(input logic [63:0] m);
    logic [63:0] mm;
    logic [29:0] acc;
    mm  = m;
    acc = '0;
    for (int i = 29; i >= 0; i--) begin
      mm = (mm * mm) >> 30;
      if (mm >= (64'd1 << 31)) begin
        mm     = mm >> 1;
        acc[i] = 1'b1;
      end
    end
    return acc;
  endfunction

  function automatic logic [29:0] log_entry_f(input int unsigned k, input int unsigned abits);
    logic [63:0] c;
    c = (64'd1 << 30) + (64'(k) << (30 - abits));
    return log2_bits_f(c);
  endfunction

  function automatic logic [30:0] rcp_entry_f(input int unsigned k, input int unsigned abits);
    logic [63:0] c;
    c = (64'd1 << 30) + (64'(k) << (30 - abits));
    return 31'(udiv_f((64'd1 << 60) + (c >> 1), c));
  endfunction

  function automatic logic [31:0] exp_entry_f(input int unsigned k, input int unsigned abits);
    logic [63:0] y;
    logic [63:0] sum;
    logic [63:0] term;
    y    = ((64'(k) << (30 - abits)) * 64'(LN2_Q30)) >> 30;
    sum  = 64'd1 << 30;
    term = 64'd1 << 30;
    for (int j = 1; j <= 20; j++) begin
      term = udiv_f((term * y) >> 30, 64'(j));
      sum  = sum + term;
    end
    return 32'(sum);
  endfunction

  // Exact floor of x / 3 for any x below 2^17.
  function automatic logic [15:0] div3_f(input logic [16:0] x);
    logic [33:0] pr;
    pr = 34'(x) * 34'(DIV3_MUL);
    return 16'(pr >> 17);
  endfunction

endpackage

// ===== src/plt_if.sv =====
// ----------------------------------------------------------------------------
// Power-law transfer channels
// Valid/ready interfaces for the sample input, the result output and the
// register write port.
// ----------------------------------------------------------------------------
interface plt_in_if import plt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [VAL_W-1:0] value;
  modport source (output valid, cmd, value, input ready);
  modport sink   (input valid, cmd, value, output ready);
endinterface

interface plt_out_if import plt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] result;
  logic                    saturated;
  modport source (output valid, result, saturated, input ready);
  modport sink   (input valid, result, saturated, output ready);
endinterface

interface plt_cfg_if import plt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/power_law_transfer.sv =====
// ----------------------------------------------------------------------------
// Power-law transfer
// Forward alpha * (value + beta) ^ gamma and inverse (value / alpha) ^ (1 /
// gamma) - beta, formed in the log domain through pipelined log2 and exp2.
//
//   Channel  Port   Direction  Payload
//   input    in_i   sink       cmd, value
//   output   out_o  source     result, saturated
//   config   cfg_i  sink       index, data
//
// One sample is taken in every cycle; each passes the input register, the
// nine log2 stages, three scaling stages and six exp2 stages on its way to
// the output. A two-entry output buffer keeps the input open while a
// finished result waits; the pipeline stops only when both entries are full.
// Reset clears the valid bits and restores the registers.
// ----------------------------------------------------------------------------
module power_law_transfer import plt_pkg::*; #(
  parameter int unsigned TABLE_ADDR_BITS = DEF_TABLE_ADDR_BITS
) (
  input logic         clk_i,
  input logic         rst_ni,
  plt_in_if.sink      in_i,
  plt_out_if.source   out_o,
  plt_cfg_if.sink     cfg_i
);

  localparam int unsigned PIPE_LEN = LOG_LAT + SCL_LAT + EXP_LAT + 1;
  localparam int unsigned LAST     = PIPE_LEN - 1;
  localparam int unsigned DIFF_W   = LOG_W + 1;
  localparam int unsigned MAG_W    = LOG_W;
  localparam int unsigned PROD_W   = MAG_W + GAM_W;

  logic [GAM_W-1:0]   gamma_q, inv_gamma_q;
  logic [ALPHA_W-1:0] alpha_q;
  logic [BETA_W-1:0]  beta_q;

  side_t              side_q [PIPE_LEN];
  logic               pipe_en;
  logic [LOGIN_W-1:0] ua_q;
  logic [LOGIN_W-1:0] x_sum;

  logic signed [LOG_W-1:0] log_a, log_b;
  logic signed [DIFF_W-1:0] diff;
  logic [MAG_W-1:0]         d1_mag_q;
  logic                     d1_neg_q, d2_neg_q;
  logic [LOG_W-1:0]         d1_lb_q, d2_lb_q;
  logic [PROD_W-1:0]        d2_prod_q;
  logic [Y_W-2:0]           smag;
  logic [Y_W-1:0]           sval;
  logic [Y_W-1:0]           y_q;
  logic [P_W-1:0]           p_exp;

  logic [P_W-1:0]   pp;
  logic [P_W:0]     rr;
  logic             f_sat;
  logic [RES_W-1:0] f_res;

  logic             out_vld_q, skid_vld_q;
  logic [RES_W-1:0] out_res_q, skid_res_q;
  logic             out_sat_q, skid_sat_q;
  logic             pop, push;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamma_q     <= GAMMA_RST;
      inv_gamma_q <= INV_GAMMA_RST;
      alpha_q     <= ALPHA_RST;
      beta_q      <= BETA_RST;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_GAMMA:     gamma_q     <= cfg_i.data[GAM_W-1:0];
        CFG_INV_GAMMA: inv_gamma_q <= cfg_i.data[GAM_W-1:0];
        CFG_ALPHA:     alpha_q     <= cfg_i.data[ALPHA_W-1:0];
        CFG_BETA:      beta_q      <= cfg_i.data[BETA_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign pipe_en    = !skid_vld_q;
  assign in_i.ready = pipe_en;
  assign x_sum      = LOGIN_W'(in_i.value) + LOGIN_W'(beta_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PIPE_LEN; i++) begin
        side_q[i] <= '0;
      end
    end else if (pipe_en) begin
      side_q[0].vld    <= in_i.valid;
      side_q[0].cmd    <= in_i.cmd;
      side_q[0].alpha0 <= (alpha_q == '0);
      side_q[0].exp0   <= in_i.cmd ? (inv_gamma_q == '0) : (gamma_q == '0);
      side_q[0].base0  <= in_i.cmd ? (in_i.value == '0) : (x_sum == '0);
      for (int i = 1; i < PIPE_LEN; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      ua_q <= in_i.cmd ? LOGIN_W'(in_i.value) : x_sum;
    end
  end

  plt_log2 #(.TABLE_ADDR_BITS(TABLE_ADDR_BITS)) u_log_a (
    .clk_i (clk_i),
    .en_i  (pipe_en),
    .u_i   (ua_q),
    .log_o (log_a)
  );

  plt_log2 #(.TABLE_ADDR_BITS(TABLE_ADDR_BITS)) u_log_b (
    .clk_i (clk_i),
    .en_i  (pipe_en),
    .u_i   (LOGIN_W'(alpha_q)),
    .log_o (log_b)
  );

  always_comb begin
    diff = side_q[LOG_LAT].cmd ? (DIFF_W'(log_a) - DIFF_W'(log_b)) : DIFF_W'(log_a);
    smag = side_q[LOG_LAT+2].cmd ? (Y_W-1)'(d2_prod_q >> 16) : (Y_W-1)'(d2_prod_q >> 12);
    sval = d2_neg_q ? (Y_W'(0) - Y_W'(smag)) : Y_W'(smag);
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      d1_neg_q  <= diff[DIFF_W-1];
      d1_mag_q  <= diff[DIFF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
      d1_lb_q   <= log_b;

      d2_prod_q <= PROD_W'(d1_mag_q) *
                   PROD_W'(side_q[LOG_LAT+1].cmd ? inv_gamma_q : gamma_q);
      d2_neg_q  <= d1_neg_q;
      d2_lb_q   <= d1_lb_q;

      y_q       <= side_q[LOG_LAT+2].cmd ? sval
                   : sval + Y_W'($signed(d2_lb_q));
    end
  end

  plt_exp2 #(.TABLE_ADDR_BITS(TABLE_ADDR_BITS)) u_exp (
    .clk_i (clk_i),
    .en_i  (pipe_en),
    .y_i   ($signed(y_q)),
    .p_o   (p_exp)
  );

  always_comb begin
    if (side_q[LAST].cmd) begin
      if (side_q[LAST].alpha0) begin
        pp = CAP_Q;
      end else if (side_q[LAST].exp0) begin
        pp = P_W'(1) << FRAC_BITS;
      end else if (side_q[LAST].base0) begin
        pp = '0;
      end else begin
        pp = p_exp;
      end
      rr = (P_W+1)'(pp) - (P_W+1)'(beta_q);
    end else begin
      if (side_q[LAST].alpha0) begin
        pp = '0;
      end else if (side_q[LAST].exp0) begin
        pp = P_W'(alpha_q);
      end else if (side_q[LAST].base0) begin
        pp = '0;
      end else begin
        pp = p_exp;
      end
      rr = (P_W+1)'(pp);
    end
    f_sat = !rr[P_W] && (rr[P_W-1:0] > P_W'(MAX_RES));
    f_res = f_sat ? MAX_RES : rr[RES_W-1:0];
  end

  assign pop  = out_vld_q && out_o.ready;
  assign push = pipe_en && side_q[LAST].vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (pop) begin
        skid_vld_q <= 1'b0;
      end
    end else if (push) begin
      if (out_vld_q && !out_o.ready) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_vld_q <= 1'b1;
      end
    end else if (pop) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (pop) begin
        out_res_q <= skid_res_q;
        out_sat_q <= skid_sat_q;
      end
    end else if (push) begin
      if (out_vld_q && !out_o.ready) begin
        skid_res_q <= f_res;
        skid_sat_q <= f_sat;
      end else begin
        out_res_q <= f_res;
        out_sat_q <= f_sat;
      end
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.result    = $signed(out_res_q);
  assign out_o.saturated = out_sat_q;

  a_sat_clamps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.saturated |-> out_res_q == MAX_RES)
    else $error("saturated result is not clamped to the top of the range");

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("buffer entry held while the output register is empty");

  a_transfer_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> side_q[0].vld)
    else $error("accepted transfer did not enter the pipeline");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> $stable(side_q[LAST]))
    else $error("pipeline moved while stalled");

endmodule

// ===== src/plt_log2.sv =====
// ----------------------------------------------------------------------------
// Power-law transfer log2 unit
// Nine-stage pipelined log2 of a positive fixed-point sample, giving a signed
// value with 30 fraction bits from a table and a short series correction.
// ----------------------------------------------------------------------------
module plt_log2 import plt_pkg::*; #(
  parameter int unsigned TABLE_ADDR_BITS = DEF_TABLE_ADDR_BITS
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [LOGIN_W-1:0]      u_i,
  output logic signed [LOG_W-1:0] log_o
);

  localparam int unsigned LSH   = 30 - TABLE_ADDR_BITS;
  localparam int unsigned TSIZE = 1 << TABLE_ADDR_BITS;
  localparam int unsigned PW    = $clog2(LOGIN_W);
  localparam int unsigned R_W   = LSH + 2;
  localparam int unsigned T_W   = R_W + 1;

  logic [30:0] rcp_rom [TSIZE];
  logic [29:0] log_rom [TSIZE];

  for (genvar gi = 0; gi < TSIZE; gi++) begin : g_rom
    localparam logic [30:0] RCP_V = rcp_entry_f(gi, TABLE_ADDR_BITS);
    localparam logic [29:0] LOG_V = log_entry_f(gi, TABLE_ADDR_BITS);
    assign rcp_rom[gi] = RCP_V;
    assign log_rom[gi] = LOG_V;
  end

  logic [PW-1:0]          p_d;
  logic [LOGIN_W+29:0]    nrm;
  logic [60:0]            zp;
  logic [30:0]            z;
  logic [R_W-1:0]         r_d;
  logic [2*R_W-1:0]       rr2, rr3, rr4;
  logic [R_W:0]           ln_d;
  logic [T_W+29:0]        tp;
  logic [30:0]            frac;

  logic [30:0]            s1_m_q, s2_m_q;
  logic [PW-1:0]          s1_p_q, s2_p_q, s3_p_q, s4_p_q, s5_p_q, s6_p_q, s7_p_q, s8_p_q;
  logic [30:0]            s2_rcp_q;
  logic [29:0]            s2_lt_q, s3_lt_q, s4_lt_q, s5_lt_q, s6_lt_q, s7_lt_q, s8_lt_q;
  logic [R_W-1:0]         s3_r_q, s4_r_q, s5_r_q, s6_r_q;
  logic [R_W-1:0]         s4_r2_q, s5_r2_q, s6_r2_q;
  logic [R_W-1:0]         s5_r3_q, s6_r4_q;
  logic [15:0]            s6_q3_q;
  logic [R_W-1:0]         s7_ln_q;
  logic [T_W-1:0]         s8_t_q;
  logic [LOG_W-1:0]       s9_lg_q;

  always_comb begin
    p_d = '0;
    for (int i = 0; i < LOGIN_W; i++) begin
      if (u_i[i]) begin
        p_d = PW'(i);
      end
    end
    nrm  = {u_i, 30'b0} >> p_d;
    zp   = 61'(s2_m_q) * 61'(s2_rcp_q);
    z    = zp[60:30];
    r_d  = (z > (31'd1 << 30)) ? R_W'(z - (31'd1 << 30)) : '0;
    rr2  = (2*R_W)'(s3_r_q) * (2*R_W)'(s3_r_q);
    rr3  = (2*R_W)'(s4_r2_q) * (2*R_W)'(s4_r_q);
    rr4  = (2*R_W)'(s5_r3_q) * (2*R_W)'(s5_r_q);
    ln_d = (R_W+1)'(s6_r_q) + (R_W+1)'(s6_q3_q) - (R_W+1)'(s6_r2_q >> 1)
           - (R_W+1)'(s6_r4_q >> 2);
    tp   = (T_W+30)'(s7_ln_q) * (T_W+30)'(INVLN2_Q30);
    frac = 31'(s8_lt_q) + 31'(s8_t_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_m_q   <= nrm[30:0];
      s1_p_q   <= p_d;

      s2_m_q   <= s1_m_q;
      s2_p_q   <= s1_p_q;
      s2_rcp_q <= rcp_rom[s1_m_q[29:LSH]];
      s2_lt_q  <= log_rom[s1_m_q[29:LSH]];

      s3_r_q   <= r_d;
      s3_p_q   <= s2_p_q;
      s3_lt_q  <= s2_lt_q;

      s4_r_q   <= s3_r_q;
      s4_r2_q  <= R_W'(rr2 >> 30);
      s4_p_q   <= s3_p_q;
      s4_lt_q  <= s3_lt_q;

      s5_r_q   <= s4_r_q;
      s5_r2_q  <= s4_r2_q;
      s5_r3_q  <= R_W'(rr3 >> 30);
      s5_p_q   <= s4_p_q;
      s5_lt_q  <= s4_lt_q;

      s6_r_q   <= s5_r_q;
      s6_r2_q  <= s5_r2_q;
      s6_r4_q  <= R_W'(rr4 >> 30);
      s6_q3_q  <= div3_f(17'(s5_r3_q));
      s6_p_q   <= s5_p_q;
      s6_lt_q  <= s5_lt_q;

      s7_ln_q  <= R_W'(ln_d);
      s7_p_q   <= s6_p_q;
      s7_lt_q  <= s6_lt_q;

      s8_t_q   <= T_W'(tp >> 30);
      s8_p_q   <= s7_p_q;
      s8_lt_q  <= s7_lt_q;

      s9_lg_q  <= (LOG_W'(s8_p_q) << 30) + LOG_W'(frac) - (LOG_W'(FRAC_BITS) << 30);
    end
  end

  assign log_o = $signed(s9_lg_q);

endmodule

// ===== src/plt_exp2.sv =====
// ----------------------------------------------------------------------------
// Power-law transfer exp2 unit
// Six-stage pipelined 2^y for a signed log value with 30 fraction bits,
// rounded to the sample format and capped at the top of its range.
// ----------------------------------------------------------------------------
module plt_exp2 import plt_pkg::*; #(
  parameter int unsigned TABLE_ADDR_BITS = DEF_TABLE_ADDR_BITS
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [Y_W-1:0] y_i,
  output logic [P_W-1:0]        p_o
);

  localparam int unsigned LSH   = 30 - TABLE_ADDR_BITS;
  localparam int unsigned TSIZE = 1 << TABLE_ADDR_BITS;
  localparam int unsigned Z_W   = LSH;
  localparam int unsigned ZP_W  = LSH + 31;
  localparam int unsigned NW    = Y_W - 30;
  localparam int unsigned NF_W  = NW + 1;
  localparam int unsigned E_W   = 31;

  logic [31:0] exp_rom [TSIZE];

  for (genvar gi = 0; gi < TSIZE; gi++) begin : g_rom
    localparam logic [31:0] EXP_V = exp_entry_f(gi, TABLE_ADDR_BITS);
    assign exp_rom[gi] = EXP_V;
  end

  logic [ZP_W-1:0]        zp;
  logic [2*Z_W-1:0]       zz2, zz3;
  logic [E_W-1:0]         e_d;
  logic [62:0]            mp;
  logic signed [NF_W-1:0] nf;
  logic [3:0]             lsh;
  logic [5:0]             rsh;
  logic [P_W-1:0]         p_d;

  logic [NW-1:0]                  e1_n_q, e2_n_q, e3_n_q, e4_n_q, e5_n_q;
  logic [TABLE_ADDR_BITS-1:0]     e1_k_q;
  logic [Z_W-1:0]                 e1_z_q, e2_z_q, e3_z_q;
  logic [Z_W-1:0]                 e2_z2_q, e3_z2_q, e3_z3_q;
  logic [31:0]                    e2_ex_q, e3_ex_q, e4_ex_q;
  logic [E_W-1:0]                 e4_e_q;
  logic [31:0]                    e5_m_q;
  logic [P_W-1:0]                 e6_p_q;

  always_comb begin
    zp  = ZP_W'(y_i[LSH-1:0]) * ZP_W'(LN2_Q30);
    zz2 = (2*Z_W)'(e1_z_q) * (2*Z_W)'(e1_z_q);
    zz3 = (2*Z_W)'(e2_z2_q) * (2*Z_W)'(e2_z_q);
    e_d = (E_W'(1) << 30) + E_W'(e3_z_q) + E_W'(e3_z2_q >> 1)
          + E_W'(div3_f(17'(e3_z3_q)) >> 1);
    mp  = 63'(e4_ex_q) * 63'(e4_e_q);
    nf  = $signed({e5_n_q[NW-1], e5_n_q}) + $signed(NF_W'(FRAC_BITS));
    lsh = 4'(nf - 30);
    rsh = 6'(30 - nf);
    if (nf >= 40) begin
      p_d = CAP_Q;
    end else if (nf >= 30) begin
      p_d = P_W'(e5_m_q) << lsh;
    end else if (nf < -10) begin
      p_d = '0;
    end else begin
      p_d = (P_W'(e5_m_q) + (P_W'(1) << (rsh - 6'd1))) >> rsh;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e1_n_q  <= y_i[Y_W-1:30];
      e1_k_q  <= y_i[29:LSH];
      e1_z_q  <= Z_W'(zp >> 30);

      e2_n_q  <= e1_n_q;
      e2_z_q  <= e1_z_q;
      e2_z2_q <= Z_W'(zz2 >> 30);
      e2_ex_q <= exp_rom[e1_k_q];

      e3_n_q  <= e2_n_q;
      e3_z_q  <= e2_z_q;
      e3_z2_q <= e2_z2_q;
      e3_z3_q <= Z_W'(zz3 >> 30);
      e3_ex_q <= e2_ex_q;

      e4_n_q  <= e3_n_q;
      e4_e_q  <= e_d;
      e4_ex_q <= e3_ex_q;

      e5_n_q  <= e4_n_q;
      e5_m_q  <= 32'(mp >> 30);

      e6_p_q  <= p_d;
    end
  end

  assign p_o = e6_p_q;

endmodule
